[src/stbs_pkg.sv]
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

   localparam int KEY_W       = 32;
   localparam int MODE_W      = 3;
   localparam int INDEX_W     = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BELOW  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ABOVE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_BELOW,
      OP_ABOVE,
      OP_FIND
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

[src/stbs_ram.sv]
// Generic single-write, single-read memory with registered read data.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/stbs_fifo.sv]
// Short command queue between the front end and the search engine.
module stbs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stbs_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output stbs_pkg::cmd_type q_cmd
);

   localparam int QD = stbs_pkg::QUEUE_DEPTH;
   localparam int PW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW = $clog2(QD + 1);

   stbs_pkg::cmd_type entry_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p == PW'(QD - 1)) ? '0 : p + PW'(1);
      return r;
   endfunction

   assign full    = (count_ff == CW'(QD));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/stbs_front.sv]
// Front end: takes request words, decodes the mode and queues valid commands.
module stbs_front (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stbs_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [stbs_pkg::KEY_W-1:0]   req_search_key,
   input  logic                                q_full,
   output logic                                push,
   output stbs_pkg::cmd_type                   push_cmd
);

   logic known;

   always_comb begin
      known        = 1'b1;
      push_cmd.op  = stbs_pkg::OP_CLEAR;
      push_cmd.key = req_search_key;
      unique case (req_mode)
         stbs_pkg::MODE_CLEAR:  push_cmd.op = stbs_pkg::OP_CLEAR;
         stbs_pkg::MODE_APPEND: push_cmd.op = stbs_pkg::OP_APPEND;
         stbs_pkg::MODE_BELOW:  push_cmd.op = stbs_pkg::OP_BELOW;
         stbs_pkg::MODE_ABOVE:  push_cmd.op = stbs_pkg::OP_ABOVE;
         stbs_pkg::MODE_FIND:   push_cmd.op = stbs_pkg::OP_FIND;
         default:               known = 1'b0;
      endcase
   end

   // Words with an unused mode are taken and dropped here.
   assign req_ready = !q_full;
   assign push      = req_valid && !q_full && known;

endmodule

[src/stbs_back.sv]
// Back end: key table, entry count, binary search engine and result register.
module stbs_back #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  stbs_pkg::cmd_type                   q_cmd,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [stbs_pkg::INDEX_W-1:0] rsp_index,
   output logic                                rsp_found,
   output logic                                rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = stbs_pkg::KEY_W;
   localparam int IW = stbs_pkg::INDEX_W;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          lo_ff, lo_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          mid_ff, mid_in;
   logic [AW-1:0]          res_ff, res_in;
   logic                   res_hit_ff, res_hit_in;
   stbs_pkg::op_type       op_ff, op_in;
   logic signed [KW-1:0]   key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [IW-1:0]   rsp_index_ff, rsp_index_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic                   out_free;
   logic [AW-1:0]          hi0, mid0, mid_left, mid_right, rd_addr;
   logic                   wr_en;
   logic signed [KW-1:0]   rd_data;
   logic                   key_lt, key_gt, key_eq;
   logic                   go_right, more;

   stbs_ram #(
      .WIDTH(KW),
      .DEPTH(DEPTH)
   ) u_key_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(q_cmd.key),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == ST_IDLE) && q_valid && out_free;
   assign wr_en    = pop && (q_cmd.op == stbs_pkg::OP_APPEND) && (count_ff < CW'(DEPTH));

   // First probe of a search sits at the midpoint of the filled range.
   assign hi0  = AW'(count_ff - CW'(1));
   assign mid0 = hi0 >> 1;

   // Both possible next probes are formed in parallel with the key compare.
   assign mid_left  = lo_ff + ((mid_ff - AW'(1) - lo_ff) >> 1);
   assign mid_right = mid_ff + AW'(1) + ((hi_ff - mid_ff - AW'(1)) >> 1);

   assign key_lt = rd_data < key_ff;
   assign key_gt = rd_data > key_ff;
   assign key_eq = rd_data == key_ff;

   always_comb begin
      unique case (op_ff)
         stbs_pkg::OP_ABOVE: go_right = !key_gt;
         default:            go_right = key_lt;
      endcase
      more = go_right ? (mid_ff < hi_ff) : (mid_ff > lo_ff);
      if (op_ff == stbs_pkg::OP_FIND && key_eq) begin
         more = 1'b0;
      end
   end

   assign rd_addr = (state_ff == ST_IDLE) ? mid0 : (go_right ? mid_right : mid_left);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      res_in          = res_ff;
      res_hit_in      = res_hit_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_index_in    = rsp_index_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_overflow_in = rsp_overflow_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (q_cmd.op)
                  stbs_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  stbs_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = '0;
                     rsp_found_in = 1'b0;
                     if (count_ff < CW'(DEPTH)) begin
                        count_in        = count_ff + CW'(1);
                        rsp_overflow_in = 1'b0;
                     end else begin
                        rsp_overflow_in = 1'b1;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        // Empty table: no bound and no hit.
                        rsp_valid_in    = 1'b1;
                        rsp_index_in    = (q_cmd.op == stbs_pkg::OP_FIND) ? '0 : '1;
                        rsp_found_in    = 1'b0;
                        rsp_overflow_in = 1'b0;
                     end else begin
                        state_in   = ST_SEARCH;
                        lo_in      = '0;
                        hi_in      = hi0;
                        mid_in     = mid0;
                        res_hit_in = 1'b0;
                        op_in      = q_cmd.op;
                        key_in     = q_cmd.key;
                     end
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if ((op_ff == stbs_pkg::OP_BELOW && key_lt) ||
                (op_ff == stbs_pkg::OP_ABOVE && key_gt)) begin
               res_hit_in = 1'b1;
               res_in     = mid_ff;
            end
            if (more) begin
               if (go_right) begin
                  lo_in  = mid_ff + AW'(1);
                  mid_in = mid_right;
               end else begin
                  hi_in  = mid_ff - AW'(1);
                  mid_in = mid_left;
               end
            end else begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_overflow_in = 1'b0;
               if (op_ff == stbs_pkg::OP_FIND) begin
                  rsp_index_in = '0;
                  rsp_found_in = key_eq;
               end else begin
                  rsp_found_in = 1'b0;
                  if (res_hit_in) begin
                     rsp_index_in = IW'(32'(res_in));
                  end else begin
                     rsp_index_in = '1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      res_ff          <= res_in;
      res_hit_ff      <= res_hit_in;
      op_ff           <= op_in;
      key_ff          <= key_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[src/sorted_table_binary_search.sv]
// Sorted key table with lower/upper bound and membership search.
// An append passes the command queue and its result is then registered in the result register, a
// clear gives no result; a query makes at most ceil(log2(n + 1)) probes for n entries.
// The back end takes one word at a time, and only while its result register is free; it does
// one key-store read and compare per probe, and a two-entry queue lets requests arrive
// meanwhile. Reset clears the search state, entry count, queue and result valid only.
module sorted_table_binary_search #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stbs_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [stbs_pkg::KEY_W-1:0]   req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [stbs_pkg::INDEX_W-1:0] rsp_index,
   output logic                                rsp_found,
   output logic                                rsp_overflow
);

   logic              q_full;
   logic              push;
   stbs_pkg::cmd_type push_cmd;
   logic              q_valid;
   stbs_pkg::cmd_type q_cmd;
   logic              pop;

   stbs_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_search_key(req_search_key),
      .q_full        (q_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   stbs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (pop),
      .q_valid (q_valid),
      .q_cmd   (q_cmd)
   );

   stbs_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_index   (rsp_index),
      .rsp_found   (rsp_found),
      .rsp_overflow(rsp_overflow)
   );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the sorted key table with binary-search queries.
`timescale 1ns / 1ps

module tb_top;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   localparam int KEY_MAX       = 32'h7FFF_FFFF;
   localparam int KEY_MIN       = 32'h8000_0000;
   localparam int SETTLE_CYCLES = 64;

   // Mode codes the block does not use; words carrying them are dropped.
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   typedef struct {
      logic [MODE_W-1:0] mode;
      int                key;
   } table_word_type;

   typedef struct {
      logic signed [INDEX_W-1:0] index;
      logic                      found;
      logic                      overflow;
   } table_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = MODE_CLEAR;
   logic signed [KEY_W-1:0]   req_search_key = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [INDEX_W-1:0] rsp_index;
   logic                      rsp_found;
   logic                      rsp_overflow;

   sorted_table_binary_search #(
      .DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_search_key (req_search_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_index      (rsp_index),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the key table as the block should hold it.
   int tbl_keys [TABLE_DEPTH];
   int tbl_count = 0;

   table_word_type pending_words [$];
   table_rsp_type  expected_rsp [$];
   int             gen_keys [$];

   int  words_taken  = 0;
   int  results_seen = 0;
   int  drops_seen   = 0;
   int  hits_seen    = 0;
   int  fail_count   = 0;
   int  stim_items   = 0;
   logic req_taken   = 1'b0;

   function automatic int probe_below(int key);
      int lo, hi, mid, res;
      lo = 0;
      hi = tbl_count - 1;
      res = -1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_keys[mid] < key) begin
            res = mid;
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return res;
   endfunction

   function automatic int probe_above(int key);
      int lo, hi, mid, res;
      lo = 0;
      hi = tbl_count - 1;
      res = -1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_keys[mid] > key) begin
            res = mid;
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return res;
   endfunction

   function automatic bit probe_find(int key);
      int lo, hi, mid;
      lo = 0;
      hi = tbl_count - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_keys[mid] == key) return 1'b1;
         if (tbl_keys[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return 1'b0;
   endfunction

   // Updates the shadow table for one accepted word; returns 1 when a result is due.
   function automatic bit apply_word(input table_word_type w, output table_rsp_type r);
      bit has_rsp;
      has_rsp = 1'b1;
      r.index = '0;
      r.found = 1'b0;
      r.overflow = 1'b0;
      case (w.mode)
         MODE_CLEAR: begin
            tbl_count = 0;
            has_rsp = 1'b0;
         end
         MODE_APPEND: begin
            if (tbl_count < TABLE_DEPTH) begin
               tbl_keys[tbl_count] = w.key;
               tbl_count++;
            end else begin
               r.overflow = 1'b1;
            end
         end
         MODE_BELOW: r.index = INDEX_W'(probe_below(w.key));
         MODE_ABOVE: r.index = INDEX_W'(probe_above(w.key));
         MODE_FIND:  r.found = probe_find(w.key);
         default:    has_rsp = 1'b0;
      endcase
      return has_rsp;
   endfunction

   function automatic int clamp_key(longint v);
      if (v > longint'(KEY_MAX)) return KEY_MAX;
      if (v < longint'(KEY_MIN)) return KEY_MIN;
      return int'(v);
   endfunction

   // Search keys lean on the table contents so that hits and near misses are common.
   function automatic int pick_query_key();
      int k;
      k = 0;
      case ($urandom_range(0, 6))
         0, 1: k = (gen_keys.size() != 0) ? gen_keys[$urandom_range(0, gen_keys.size() - 1)]
                                          : int'($urandom());
         2: begin
            k = (gen_keys.size() != 0) ? gen_keys[$urandom_range(0, gen_keys.size() - 1)] : 0;
            k = clamp_key(longint'(k) + (($urandom_range(0, 1) == 0) ? -1 : 1));
         end
         3: k = int'($urandom());
         4: k = KEY_MIN;
         5: k = KEY_MAX;
         default: k = $urandom_range(0, 16) - 8;
      endcase
      return k;
   endfunction

   task automatic push_word(logic [MODE_W-1:0] mode, int key);
      table_word_type w;
      w.mode = mode;
      w.key = key;
      pending_words.push_back(w);
      if (mode <= MODE_FIND) stim_items++;
   endtask

   task automatic push_query(int key);
      logic [MODE_W-1:0] m;
      case ($urandom_range(0, 2))
         0: m = MODE_BELOW;
         1: m = MODE_ABOVE;
         default: m = MODE_FIND;
      endcase
      push_word(m, key);
   endtask

   // Lets the block run dry: no word waiting, no result owed, then a quiet stretch.
   task automatic settle_block();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of words separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_req
      table_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Word still waiting for ready; hold it.
      end else if (gap_left > 0 || pending_words.size() == 0) begin
         req_valid <= 1'b0;
         if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
         w = pending_words.pop_front();
         req_mode <= w.mode;
         req_search_key <= w.key;
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap_left <= $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // Receiver: a rotating ready pattern, reloaded now and then, sometimes all ones.
   logic [15:0] ready_pat   = 16'hFFFF;
   int          stall_timer = 0;

   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_timer <= $urandom_range(40, 160);
         ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
         rsp_ready <= 1'b1;
      end else begin
         stall_timer <= stall_timer - 1;
         ready_pat <= {ready_pat[0], ready_pat[15:1]};
         rsp_ready <= ready_pat[0];
      end
   end

   always @(posedge clock) begin : take_req
      table_word_type w;
      table_rsp_type  r;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            w.mode = req_mode;
            w.key = req_search_key;
            words_taken++;
            if (apply_word(w, r)) expected_rsp.push_back(r);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      table_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_overflow === 1'b1) drops_seen++;
         if (rsp_found === 1'b1) hits_seen++;
         if (expected_rsp.size() == 0) begin
            $error("result word with nothing expected: index %0d found %0b overflow %0b",
                   rsp_index, rsp_found, rsp_overflow);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_index !== want.index) begin
               $error("index: expected %0d, got %0d", want.index, rsp_index);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_found);
               fail_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results still expected", expected_rsp.size());
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin : stimulus
      int n, m, spread, prev, key, episode, target;
      bit sorted;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme keys, duplicates, unused modes, clear, unsorted.
      push_word(MODE_BELOW, 0);
      push_word(MODE_ABOVE, 0);
      push_word(MODE_FIND, 0);
      push_word(MODE_APPEND, KEY_MIN);
      push_word(MODE_APPEND, -5);
      push_word(MODE_APPEND, 0);
      push_word(MODE_APPEND, 0);
      push_word(MODE_APPEND, 7);
      push_word(MODE_APPEND, KEY_MAX);
      push_word(MODE_BELOW, KEY_MIN);
      push_word(MODE_BELOW, KEY_MAX);
      push_word(MODE_ABOVE, KEY_MAX);
      push_word(MODE_ABOVE, KEY_MIN);
      push_word(MODE_FIND, 0);
      push_word(MODE_FIND, 3);
      push_word(MODE_FIND, KEY_MAX);
      push_word(MODE_BELOW, 0);
      push_word(MODE_ABOVE, 0);
      for (int u = MODE_UNUSED_LO; u <= MODE_UNUSED_HI; u++)
         push_word(MODE_W'(u), int'($urandom()));
      push_word(MODE_CLEAR, int'($urandom()));
      push_word(MODE_FIND, 0);
      push_word(MODE_APPEND, 10);
      push_word(MODE_APPEND, 3);
      push_word(MODE_FIND, 3);
      push_word(MODE_BELOW, 5);
      settle_block();

      // Random episodes: fill a table (mostly in order), then query it with some noise.
      target = stim_items + 300;
      episode = 0;
      gen_keys.delete();
      while (stim_items < target) begin
         if ($urandom_range(0, 4) != 0 || gen_keys.size() > 600) begin
            push_word(MODE_CLEAR, int'($urandom()));
            gen_keys.delete();
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 24);
         sorted = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 3))
            0: spread = 3;
            1: spread = 100;
            2: spread = 1 << 20;
            default: spread = 1 << 28;
         endcase
         if (gen_keys.size() != 0) prev = gen_keys[$];
         else if ($urandom_range(0, 3) == 0) prev = KEY_MIN;
         else prev = int'($urandom());
         for (int i = 0; i < n; i++) begin
            if (sorted) key = clamp_key(longint'(prev) + longint'($urandom_range(0, spread)));
            else if ($urandom_range(0, 1) == 0) key = int'($urandom());
            else key = $urandom_range(0, 40) - 20;
            push_word(MODE_APPEND, key);
            gen_keys.push_back(key);
            prev = key;
         end
         m = $urandom_range(3, 30);
         for (int i = 0; i < m; i++) begin
            case ($urandom_range(0, 19))
               0: push_word(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                            int'($urandom()));
               1: begin
                  // A stray append in the middle of the queries breaks the ordering.
                  key = int'($urandom());
                  push_word(MODE_APPEND, key);
                  gen_keys.push_back(key);
               end
               2: begin
                  push_word(MODE_CLEAR, int'($urandom()));
                  gen_keys.delete();
               end
               default: push_query(pick_query_key());
            endcase
         end
         episode++;
         if (episode % 8 == 0) settle_block();
      end
      settle_block();

      // Full table: every slot written, further appends must be dropped.
      push_word(MODE_CLEAR, 0);
      gen_keys.delete();
      prev = KEY_MIN;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         key = (i == 0) ? KEY_MIN : clamp_key(longint'(prev) +
                                              longint'($urandom_range(0, 8_000_000)));
         push_word(MODE_APPEND, key);
         gen_keys.push_back(key);
         prev = key;
      end
      repeat (3) push_word(MODE_APPEND, int'($urandom()));
      push_word(MODE_BELOW, KEY_MAX);
      push_word(MODE_ABOVE, KEY_MIN);
      push_word(MODE_FIND, gen_keys[$]);
      push_word(MODE_FIND, gen_keys[0]);
      push_word(MODE_BELOW, gen_keys[$]);
      push_word(MODE_ABOVE, gen_keys[0]);
      repeat (12) push_query(pick_query_key());
      push_word(MODE_UNUSED_HI, int'($urandom()));
      push_word(MODE_CLEAR, 0);
      push_word(MODE_APPEND, 42);
      push_word(MODE_FIND, 42);
      push_word(MODE_BELOW, 42);
      settle_block();

      $display("Accepted %0d words (%0d in the valid modes); checked %0d results,",
               words_taken, stim_items, results_seen);
      $display("including %0d appends dropped on a full table and %0d find hits.",
               drops_seen, hits_seen);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d failures, %0d results never arrived", fail_count, expected_rsp.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_fifo.sv
src/stbs_front.sv
src/stbs_back.sv
src/sorted_table_binary_search.sv
tb/sv/tb_top.sv
